### hdl/csa_pkg.sv
// Shared types and constants for the circular stack calculator.
package csa_pkg;

   localparam int CSA_DEPTH = 8;
   localparam int WORD_W    = 32;
   localparam int CMD_W     = 4;

   typedef enum logic [CMD_W-1:0] {
      OP_PUSH = 4'd0,
      OP_POP  = 4'd1,
      OP_AND  = 4'd2,
      OP_MUL  = 4'd3,
      OP_ADD  = 4'd4,
      OP_INC  = 4'd5,
      OP_SUB  = 4'd6,
      OP_DEC  = 4'd7,
      OP_DIV  = 4'd8,
      OP_XOR  = 4'd9,
      OP_OR   = 4'd10,
      OP_DUMP = 4'd11
   } csa_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PUSH,
      ST_READ_A,
      ST_LOAD_A,
      ST_LOAD_T,
      ST_EXEC,
      ST_DIV_WAIT,
      ST_WRITE,
      ST_EMIT,
      ST_DUMP_RD,
      ST_DUMP_EMIT
   } csa_state_type;

   typedef enum logic [1:0] {
      RD_TOP,
      RD_BELOW,
      RD_DUMP
   } csa_rd_sel_type;

   // controller -> datapath
   typedef struct packed {
      logic           take;       // latch push word at accept
      logic           rd_en;
      csa_rd_sel_type rd_sel;
      logic           push;       // top up, write word, result = word
      logic           pop;        // right operand = read word, top down
      logic           unary;      // top +/- 1 written back
      logic           load_t;     // left operand = read word
      logic           exec;       // result = logic/arith op
      logic           div_start;
      logic           div_take;   // result = quotient or all ones
      logic           wr_res;     // write result over top
      logic           emit;       // load response register from result
      logic           dump_init;
      logic           dump_emit;  // load response register from read word
      logic           dump_step;
      csa_op_type     op;
   } csa_ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic div_done;
      logic rsp_free;
      logic dump_last;
   } csa_stat_type;

endpackage

### hdl/csa_if.sv
// Request and response channel interfaces.
interface csa_req_if;
   logic                       valid;
   logic                       ready;
   logic [csa_pkg::CMD_W-1:0]  cmd;
   logic [csa_pkg::WORD_W-1:0] value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface csa_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [csa_pkg::WORD_W-1:0] data;
   logic                       last;
   logic                       div_zero;

   modport source (output valid, output data, output last, output div_zero, input ready);
   modport sink   (input valid, input data, input last, input div_zero, output ready);
endinterface

### hdl/csa_ctrl.sv
// Command sequencer for the stack calculator.
module csa_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [csa_pkg::CMD_W-1:0] req_cmd,
   output csa_pkg::csa_ctl_type      ctl,
   input  csa_pkg::csa_stat_type     stat
);
   import csa_pkg::*;

   csa_state_type state_ff, state_in;
   csa_op_type    op_ff, op_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      req_ready  = 1'b0;
      ctl        = '0;
      ctl.rd_sel = RD_TOP;
      ctl.op     = op_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.take = 1'b1;
               op_in    = csa_op_type'(req_cmd);
               case (req_cmd)
                  OP_PUSH: state_in = ST_PUSH;
                  OP_POP, OP_INC, OP_DEC, OP_AND, OP_MUL, OP_ADD,
                  OP_SUB, OP_DIV, OP_XOR, OP_OR: state_in = ST_READ_A;
                  OP_DUMP: begin
                     ctl.dump_init = 1'b1;
                     state_in      = ST_DUMP_RD;
                  end
                  default: state_in = ST_IDLE;   // unused codes are dropped
               endcase
            end
         end
         ST_PUSH: begin
            ctl.push = 1'b1;
            state_in = ST_EMIT;
         end
         ST_READ_A: begin
            ctl.rd_en  = 1'b1;
            ctl.rd_sel = RD_TOP;
            state_in   = ST_LOAD_A;
         end
         ST_LOAD_A: begin
            case (op_ff)
               OP_POP: begin
                  ctl.pop  = 1'b1;
                  state_in = ST_EMIT;
               end
               OP_INC, OP_DEC: begin
                  ctl.unary = 1'b1;
                  state_in  = ST_EMIT;
               end
               default: begin
                  ctl.pop    = 1'b1;
                  ctl.rd_en  = 1'b1;
                  ctl.rd_sel = RD_BELOW;
                  state_in   = ST_LOAD_T;
               end
            endcase
         end
         ST_LOAD_T: begin
            ctl.load_t = 1'b1;
            state_in   = ST_EXEC;
         end
         ST_EXEC: begin
            if (op_ff == OP_DIV) begin
               ctl.div_start = 1'b1;
               state_in      = ST_DIV_WAIT;
            end else begin
               ctl.exec = 1'b1;
               state_in = ST_WRITE;
            end
         end
         ST_DIV_WAIT: begin
            if (stat.div_done) begin
               ctl.div_take = 1'b1;
               state_in     = ST_WRITE;
            end
         end
         ST_WRITE: begin
            ctl.wr_res = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.rsp_free) begin
               ctl.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DUMP_RD: begin
            ctl.rd_en  = 1'b1;
            ctl.rd_sel = RD_DUMP;
            state_in   = ST_DUMP_EMIT;
         end
         ST_DUMP_EMIT: begin
            if (stat.rsp_free) begin
               ctl.dump_emit = 1'b1;
               if (stat.dump_last) begin
                  state_in = ST_IDLE;
               end else begin
                  ctl.dump_step = 1'b1;
                  state_in      = ST_DUMP_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

### hdl/csa_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module csa_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [csa_pkg::WORD_W-1:0] dividend,
   input  logic [csa_pkg::WORD_W-1:0] divisor,
   output logic                       done,
   output logic [csa_pkg::WORD_W-1:0] quotient
);
   import csa_pkg::*;

   localparam int CW = $clog2(WORD_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] quo_ff, quo_in;
   logic [WORD_W-1:0] dvs_ff, dvs_in;
   logic [WORD_W:0]   shifted;
   logic [WORD_W:0]   diff;

   assign shifted = {rem_ff, quo_ff[WORD_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(WORD_W - 1);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[WORD_W]) begin
            rem_in = diff[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### hdl/csa_datapath.sv
// Stack memory, pointers, operand and result registers, response register.
module csa_datapath #(
   parameter int DEPTH = csa_pkg::CSA_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  csa_pkg::csa_ctl_type       ctl,
   output csa_pkg::csa_stat_type      stat,
   input  logic [csa_pkg::WORD_W-1:0] req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [csa_pkg::WORD_W-1:0] rsp_data,
   output logic                       rsp_last,
   output logic                       rsp_div_zero
);
   import csa_pkg::*;

   localparam int PW = $clog2(DEPTH);

   function automatic logic [PW-1:0] ptr_up(input logic [PW-1:0] p);
      ptr_up = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PW-1:0] ptr_down(input logic [PW-1:0] p);
      ptr_down = (p == '0) ? PW'(DEPTH - 1) : p - 1'b1;
   endfunction

   // stack store; a slot never written reads as zero
   logic [WORD_W-1:0] stack_ff [DEPTH];
   logic [DEPTH-1:0]  vld_ff;

   logic [PW-1:0]     top_ff, top_in;
   logic [PW-1:0]     dump_ptr_ff, dump_ptr_in;
   logic [PW-1:0]     dump_cnt_ff, dump_cnt_in;
   logic [WORD_W-1:0] value_ff;
   logic [WORD_W-1:0] rd_data_ff;
   logic              rd_vld_ff;
   logic [WORD_W-1:0] a_ff;
   logic [WORD_W-1:0] t_ff;
   logic [WORD_W-1:0] res_ff, res_in;
   logic              dz_ff, dz_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_dz_ff, rsp_dz_in;

   logic [PW-1:0]     rd_addr;
   logic              wr_en;
   logic [PW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [WORD_W-1:0] rd_word;
   logic [WORD_W-1:0] unary_word;
   logic [WORD_W-1:0] alu_word;
   logic              div_done;
   logic [WORD_W-1:0] div_quo;
   logic              rsp_free;

   csa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.div_start),
      .dividend (t_ff),
      .divisor  (a_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rd_word    = rd_vld_ff ? rd_data_ff : '0;
   assign unary_word = (ctl.op == OP_INC) ? rd_word + WORD_W'(1) : rd_word - WORD_W'(1);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case (ctl.rd_sel)
         RD_TOP:   rd_addr = top_ff;
         RD_BELOW: rd_addr = ptr_down(top_ff);
         RD_DUMP:  rd_addr = dump_ptr_ff;
         default:  rd_addr = top_ff;
      endcase
   end

   always_comb begin
      case (ctl.op)
         OP_AND:  alu_word = t_ff & a_ff;
         OP_MUL:  alu_word = t_ff * a_ff;
         OP_ADD:  alu_word = t_ff + a_ff;
         OP_SUB:  alu_word = t_ff - a_ff;
         OP_XOR:  alu_word = t_ff ^ a_ff;
         OP_OR:   alu_word = t_ff | a_ff;
         default: alu_word = '0;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = top_ff;
      wr_data = res_ff;
      if (ctl.push) begin
         wr_en   = 1'b1;
         wr_addr = ptr_up(top_ff);
         wr_data = value_ff;
      end else if (ctl.unary) begin
         wr_en   = 1'b1;
         wr_data = unary_word;
      end else if (ctl.wr_res) begin
         wr_en   = 1'b1;
      end
   end

   always_comb begin
      top_in      = top_ff;
      dump_ptr_in = dump_ptr_ff;
      dump_cnt_in = dump_cnt_ff;
      res_in      = res_ff;
      dz_in       = dz_ff;
      if (ctl.push) begin
         top_in = ptr_up(top_ff);
         res_in = value_ff;
         dz_in  = 1'b0;
      end
      if (ctl.pop) begin
         top_in = ptr_down(top_ff);
         res_in = rd_word;
         dz_in  = 1'b0;
      end
      if (ctl.unary) begin
         res_in = unary_word;
         dz_in  = 1'b0;
      end
      if (ctl.exec) begin
         res_in = alu_word;
         dz_in  = 1'b0;
      end
      if (ctl.div_take) begin
         res_in = (a_ff == '0) ? '1 : div_quo;
         dz_in  = (a_ff == '0);
      end
      if (ctl.dump_init) begin
         dump_ptr_in = ptr_up(top_ff);
         dump_cnt_in = '0;
      end
      if (ctl.dump_step) begin
         dump_ptr_in = ptr_up(dump_ptr_ff);
         dump_cnt_in = dump_cnt_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_dz_in    = rsp_dz_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctl.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
         rsp_last_in  = 1'b1;
         rsp_dz_in    = dz_ff;
      end else if (ctl.dump_emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rd_word;
         rsp_last_in  = stat.dump_last;
         rsp_dz_in    = 1'b0;
      end
   end

   // memory port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= stack_ff[rd_addr];
         rd_vld_ff  <= vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.take) begin
         value_ff <= req_value;
      end
      if (ctl.pop) begin
         a_ff <= rd_word;
      end
      if (ctl.load_t) begin
         t_ff <= rd_word;
      end
      dump_ptr_ff <= dump_ptr_in;
      dump_cnt_ff <= dump_cnt_in;
      res_ff      <= res_in;
      dz_ff       <= dz_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_dz_ff   <= rsp_dz_in;
   end

   assign stat.div_done  = div_done;
   assign stat.rsp_free  = rsp_free;
   assign stat.dump_last = (dump_cnt_ff == PW'(DEPTH - 1));

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_div_zero = rsp_dz_ff;

endmodule

### hdl/circular_stack_alu.sv
// Top level of the reverse-Polish calculator on a circular word stack.
//
//  channel   direction  handshake          payload
//  req_bus   in         valid / ready      cmd[3:0], value[31:0]
//  rsp_bus   out        valid / ready      data[31:0], last, div_zero
//
// Per command: push writes above the top, then responds; pop and inc/dec read
//   the top, pop it or write it back, then respond; binary ops also read the
//   word below, operate (div: one quotient bit per cycle), write back and
//   respond; dump reads each slot on the single stack memory port, responds.
// Reset is synchronous; per-slot valid bits clear the stack at once, no sweep.
// A stalled response holds the sequencer at its output step; a new command
// is taken while the previous final response still waits.
module circular_stack_alu #(
   parameter int DEPTH = csa_pkg::CSA_DEPTH
) (
   input logic       clock,
   input logic       reset,
   csa_req_if.sink   req_bus,
   csa_rsp_if.source rsp_bus
);
   import csa_pkg::*;

   csa_ctl_type  ctl;    // sequencer commands
   csa_stat_type stat;   // datapath status

   // sequencer: one command at a time, steps the stack through its read,
   // operate, write-back and respond phases
   csa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .req_cmd   (req_bus.cmd),
      .ctl       (ctl),
      .stat      (stat)
   );

   // stack store, top pointer, operands, ALU, divider and response register
   csa_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .stat         (stat),
      .req_value    (req_bus.value),
      .rsp_valid    (rsp_bus.valid),
      .rsp_ready    (rsp_bus.ready),
      .rsp_data     (rsp_bus.data),
      .rsp_last     (rsp_bus.last),
      .rsp_div_zero (rsp_bus.div_zero)
   );

endmodule

### hdl/csa_checker.sv
// Port-level assertions for the stack calculator, bound to the top level.
module csa_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [csa_pkg::WORD_W-1:0] rsp_data,
   input logic                       rsp_last,
   input logic                       rsp_div_zero
);
   import csa_pkg::*;

   // response valid holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data) && $stable(rsp_last)
                                  && $stable(rsp_div_zero))
      else $error("response payload changed while stalled");

   // division-by-zero flag only on a single-transaction command
   a_dz_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_zero |-> rsp_last)
      else $error("div_zero on a non-final transaction");

   // nothing is offered on the first edge out of reset
   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind circular_stack_alu csa_checker u_csa_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_data     (rsp_bus.data),
   .rsp_last     (rsp_bus.last),
   .rsp_div_zero (rsp_bus.div_zero)
);
